// File: hdl/ct_pkg.sv
package ct_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 128;
  localparam int ID_W  = 16;
  localparam int IDX_W = 7;
  localparam int CNT_W = 8;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [ID_W-1:0]    key_id;
    logic [IDX_W-1:0]   slot_index;
  } in_t;

  typedef struct packed {
    status_t            status;
    logic [ID_W-1:0]    result_id;
    logic [IDX_W-1:0]   result_index;
    logic [CNT_W-1:0]   entries_used;
  } out_t;

endpackage

// File: hdl/ct_ram.sv
module ct_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/compact_id_table_unit.sv
// Compacting id table: holds up to TABLE_DEPTH distinct ids packed in positions
// 0 .. entries_used-1 and answers one command per input transfer with exactly one
// result transfer. Add hands out the smallest positive id not in use, remove
// deletes an id and closes the gap, find returns an id's position and read
// returns the id at a position. After reset the block clears its id-in-use map
// and holds in_ready low meanwhile. Commands are processed one at a time by a
// small sequencer that walks the id memory or the in-use map one entry per cycle
// through a single comparator. The result sits in an output register, so a new
// command is taken while it waits.
module compact_id_table_unit #(
  parameter int TABLE_DEPTH = ct_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  ct_pkg::in_t  in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output ct_pkg::out_t out_data
);

  localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int IDW  = ct_pkg::ID_W;
  localparam int IXW  = ct_pkg::IDX_W;
  localparam int NW   = ct_pkg::CNT_W;
  localparam int CMPW = (CW > IXW) ? CW : IXW;

  // sequencer states
  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,  // sweep the in-use map to zero after reset
    S_IDLE  = 7'b0000010,
    S_FREE  = 7'b0000100,  // scan in-use map for the first free id
    S_FIND  = 7'b0001000,  // scan id memory for the key
    S_SHIFT = 7'b0010000,  // move later entries down one place
    S_READ  = 7'b0100000,  // wait for the id memory read
    S_DONE  = 7'b1000000   // hand the result to the output register
  } state_t;

  state_t               state_r, state_nxt;
  logic [AW-1:0]        ptr_r, ptr_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  ct_pkg::cmd_t         cmd_r, cmd_nxt;
  logic [IDW-1:0]       key_r, key_nxt;
  ct_pkg::status_t      res_status_r, res_status_nxt;
  logic [IDW-1:0]       res_id_r, res_id_nxt;
  logic [IXW-1:0]       res_idx_r, res_idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  ct_pkg::out_t         out_data_r, out_data_nxt;

  // id memory and in-use map (map entry k marks id k+1)
  logic                 id_we;
  logic [AW-1:0]        id_waddr;
  logic [IDW-1:0]       id_wdata;
  logic [IDW-1:0]       id_rdata;
  logic                 map_we;
  logic [AW-1:0]        map_waddr;
  logic                 map_wdata;
  logic                 map_rdata;

  // shared scan comparator
  logic [IDW-1:0]       scan_word;
  logic [IDW-1:0]       scan_ref;
  logic                 scan_hit;

  logic [CW-1:0]        ptr_inc;
  logic                 more_left;
  logic                 table_full;
  logic                 slot_out;

  // both memories read ahead at the next pointer, so read data always
  // belongs to the current pointer
  ct_ram #(.WIDTH(IDW), .DEPTH(TABLE_DEPTH)) u_id_ram (
    .clk   (clk),
    .we    (id_we),
    .waddr (id_waddr),
    .wdata (id_wdata),
    .raddr (ptr_nxt),
    .rdata (id_rdata)
  );

  ct_ram #(.WIDTH(1), .DEPTH(TABLE_DEPTH)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (ptr_nxt),
    .rdata (map_rdata)
  );

  // free-id scan looks for a zero map bit, key scan for an equal id
  assign scan_word  = (state_r == S_FREE) ? IDW'(map_rdata) : id_rdata;
  assign scan_ref   = (state_r == S_FREE) ? '0 : key_r;
  assign scan_hit   = (scan_word == scan_ref);

  assign ptr_inc    = CW'(ptr_r) + CW'(1);
  assign more_left  = (ptr_inc < count_r);
  assign table_full = (count_r == CW'(TABLE_DEPTH));
  assign slot_out   = (CMPW'(in_data.slot_index) >= CMPW'(count_r));

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_comb begin
    state_nxt      = state_r;
    ptr_nxt        = ptr_r;
    count_nxt      = count_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_idx_nxt    = res_idx_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    id_we          = 1'b0;
    id_waddr       = ptr_r - AW'(1);
    id_wdata       = id_rdata;
    map_we         = 1'b0;
    map_waddr      = ptr_r;
    map_wdata      = 1'b0;

    case (state_r)
      S_CLEAR: begin
        map_we = 1'b1;
        if (ptr_r == AW'(TABLE_DEPTH - 1)) begin
          ptr_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt        = in_data.cmd;
          key_nxt        = in_data.key_id;
          ptr_nxt        = '0;
          res_status_nxt = ct_pkg::ST_OK;
          res_id_nxt     = '0;
          res_idx_nxt    = '0;
          case (in_data.cmd)
            ct_pkg::CMD_ADD: begin
              if (table_full) begin
                res_status_nxt = ct_pkg::ST_FULL;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_FREE;
              end
            end
            ct_pkg::CMD_REMOVE, ct_pkg::CMD_FIND: begin
              if (count_r == '0) begin
                res_status_nxt = ct_pkg::ST_NOT_FOUND;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_FIND;
              end
            end
            ct_pkg::CMD_READ: begin
              if (slot_out) begin
                res_status_nxt = ct_pkg::ST_RANGE;
                state_nxt      = S_DONE;
              end else begin
                ptr_nxt   = AW'(in_data.slot_index);
                state_nxt = S_READ;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_FREE: begin
        if (scan_hit) begin
          // id ptr+1 is free: append it and mark it used
          id_we      = 1'b1;
          id_waddr   = count_r[AW-1:0];
          id_wdata   = IDW'(ptr_inc);
          map_we     = 1'b1;
          map_wdata  = 1'b1;
          count_nxt  = count_r + CW'(1);
          res_id_nxt = IDW'(ptr_inc);
          state_nxt  = S_DONE;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end

      S_FIND: begin
        if (scan_hit) begin
          if (cmd_r == ct_pkg::CMD_FIND) begin
            res_idx_nxt = IXW'(ptr_r);
            state_nxt   = S_DONE;
          end else begin
            // a stored id is never zero, so key-1 is its map entry
            map_we    = 1'b1;
            map_waddr = AW'(key_r - IDW'(1));
            if (more_left) begin
              ptr_nxt   = ptr_r + AW'(1);
              state_nxt = S_SHIFT;
            end else begin
              count_nxt = count_r - CW'(1);
              state_nxt = S_DONE;
            end
          end
        end else if (more_left) begin
          ptr_nxt = ptr_r + AW'(1);
        end else begin
          res_status_nxt = ct_pkg::ST_NOT_FOUND;
          state_nxt      = S_DONE;
        end
      end

      S_SHIFT: begin
        // entry at ptr moves to ptr-1 while ptr+1 is fetched
        id_we = 1'b1;
        if (more_left) begin
          ptr_nxt = ptr_r + AW'(1);
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_DONE;
        end
      end

      S_READ: begin
        res_id_nxt = id_rdata;
        state_nxt  = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.status       = res_status_r;
          out_data_nxt.result_id    = res_id_r;
          out_data_nxt.result_index = res_idx_r;
          out_data_nxt.entries_used = NW'(count_r);
          state_nxt                 = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ptr_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_idx_r    <= res_idx_nxt;
    out_data_r   <= out_data_nxt;
  end

  // occupancy never exceeds the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  // an appended id is positive and no larger than the table depth
  a_new_id_range: assert property (@(posedge clk) disable iff (!rst_n)
    (id_we && state_r == S_FREE) |->
      (id_wdata != '0 && id_wdata <= IDW'(TABLE_DEPTH)))
    else $error("allocated id out of range");

  // compaction never writes the entry being fetched
  a_shift_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && state_nxt == S_SHIFT) |-> (id_waddr != ptr_nxt))
    else $error("shift write collides with read address");

  // one command at a time: no new transfer right after one is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a command is in progress");

  // a remove or add changes the count by exactly one
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      (count_r == $past(count_r) + CW'(1) || count_r == $past(count_r) - CW'(1)))
    else $error("entry count jumped");

endmodule

// File: test/tb_compact_id_table_unit.sv
module tb_compact_id_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBL_DEPTH   = ct_pkg::DEFAULT_TABLE_DEPTH;
  localparam int ID_W        = ct_pkg::ID_W;
  localparam int IDX_W       = ct_pkg::IDX_W;
  localparam int CNT_W       = ct_pkg::CNT_W;
  localparam int RAND_ITEMS  = 700;
  localparam int IDLE_PCT    = 23;
  localparam int HOLD_AT     = 480;     // accepted commands before the long out_ready hold-off
  localparam int HOLD_CYCLES = 2500;
  localparam int TAIL_CYCLES = 150;     // a full-table scan plus margin
  localparam int CYCLE_LIMIT = 1000000;

  typedef enum int {PH_FILL, PH_MIX, PH_DRAIN} phase_t;

  // shadow copy of the table: predicts one answer per accepted command and
  // checks answers in order
  class id_table_scoreboard;
    logic [ID_W-1:0] ids [TBL_DEPTH];
    int unsigned     used;
    ct_pkg::out_t    pending_answers [$];
    int              errors;
    int              accepted;
    int              answered;
    int              cmd_seen [4];
    int              status_seen [4];
    int unsigned     peak_used;

    function new();
      used = 0;
      errors = 0;
      accepted = 0;
      answered = 0;
      peak_used = 0;
      foreach (cmd_seen[i]) cmd_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      foreach (ids[i]) ids[i] = '0;
    endfunction

    function int position_of(logic [ID_W-1:0] id);
      for (int unsigned i = 0; i < used; i++) begin
        if (ids[i] == id) return int'(i);
      end
      return -1;
    endfunction

    function logic [ID_W-1:0] lowest_unused();
      int unsigned cand;
      for (cand = 1; cand <= used; cand++) begin
        if (position_of(cand[ID_W-1:0]) < 0) break;
      end
      return cand[ID_W-1:0];
    endfunction

    // an id now in the table, or zero when it is empty
    function logic [ID_W-1:0] any_present();
      if (used == 0) return '0;
      return ids[$urandom_range(0, used - 1)];
    endfunction

    function void note_command(ct_pkg::in_t c);
      ct_pkg::out_t a;
      int           pos;
      a = '0;
      a.status = ct_pkg::ST_OK;
      accepted++;
      cmd_seen[c.cmd]++;
      case (c.cmd)
        ct_pkg::CMD_ADD: begin
          if (used >= TBL_DEPTH) begin
            a.status = ct_pkg::ST_FULL;
          end else begin
            a.result_id = lowest_unused();
            ids[used] = a.result_id;
            used++;
          end
        end
        ct_pkg::CMD_REMOVE: begin
          pos = position_of(c.key_id);
          if (pos < 0) begin
            a.status = ct_pkg::ST_NOT_FOUND;
          end else begin
            // close the gap left by the removed id
            for (int unsigned j = pos; j + 1 < used; j++) ids[j] = ids[j + 1];
            used--;
          end
        end
        ct_pkg::CMD_FIND: begin
          pos = position_of(c.key_id);
          if (pos < 0) a.status = ct_pkg::ST_NOT_FOUND;
          else a.result_index = pos[IDX_W-1:0];
        end
        default: begin
          if (c.slot_index >= used) a.status = ct_pkg::ST_RANGE;
          else a.result_id = ids[c.slot_index];
        end
      endcase
      a.entries_used = used[CNT_W-1:0];
      if (used > peak_used) peak_used = used;
      status_seen[a.status]++;
      pending_answers.push_back(a);
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 30) $display("MISMATCH answer %0d: %s", answered, what);
    endtask

    task check_answer(ct_pkg::out_t got);
      ct_pkg::out_t want;
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("unexpected answer status=%0d id=%0d",
                                  got.status, got.result_id));
        return;
      end
      want = pending_answers.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.result_id !== want.result_id)
        report_mismatch($sformatf("result_id %0d, want %0d", got.result_id, want.result_id));
      if (got.result_index !== want.result_index)
        report_mismatch($sformatf("result_index %0d, want %0d",
                                  got.result_index, want.result_index));
      if (got.entries_used !== want.entries_used)
        report_mismatch($sformatf("entries_used %0d, want %0d",
                                  got.entries_used, want.entries_used));
      answered++;
    endtask
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_valid;
  logic         in_ready;
  ct_pkg::in_t  in_data;
  logic         out_valid;
  logic         out_ready;
  ct_pkg::out_t out_data;

  id_table_scoreboard sb;
  bit steady;          // no idling on either side while set
  bit hold_done;
  int cycle_count;
  int full_hits;

  compact_id_table_unit #(.TABLE_DEPTH(TBL_DEPTH)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    steady = 1'b0;
    hold_done = 1'b0;
    cycle_count = 0;
    full_hits = 0;
    sb = new();
  end

  always #1 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // monitor both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_command(in_data);
      if (out_valid && out_ready) sb.check_answer(out_data);
    end
  end

  // result side: random back-pressure, plus one long hold-off so the output
  // register fills and the block stops taking commands
  initial begin
    int held;
    @(negedge clk);
    forever begin
      if (!hold_done && sb.accepted >= HOLD_AT) begin
        out_ready = 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(negedge clk);
          held++;
        end
        hold_done = 1'b1;
      end
      if (steady) out_ready = 1'b1;
      else out_ready = ($urandom_range(0, 99) >= IDLE_PCT);
      @(negedge clk);
    end
  end

  // offer one command and hold it until the transfer; returns at the next falling edge
  task automatic send_command(input ct_pkg::in_t c);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = c;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // directed command with random filler in the fields the command ignores
  function automatic ct_pkg::in_t mk(ct_pkg::cmd_t op, logic [ID_W-1:0] key,
                                     logic [IDX_W-1:0] slot);
    ct_pkg::in_t c;
    c.cmd = op;
    c.key_id = (op == ct_pkg::CMD_REMOVE || op == ct_pkg::CMD_FIND) ? key : ID_W'($urandom);
    c.slot_index = (op == ct_pkg::CMD_READ) ? slot : IDX_W'($urandom);
    return c;
  endfunction

  // mostly well-formed commands for the phase, some pure noise
  function automatic ct_pkg::in_t make_command(phase_t ph);
    ct_pkg::in_t c;
    int          r;
    c.cmd = ct_pkg::cmd_t'($urandom_range(0, 3));
    c.key_id = ID_W'($urandom);
    c.slot_index = IDX_W'($urandom);
    if ($urandom_range(0, 99) < 8) return c;
    r = $urandom_range(0, 99);
    case (ph)
      PH_FILL: begin
        if (r < 88) c.cmd = ct_pkg::CMD_ADD;
        else if (r < 94) c.cmd = ct_pkg::CMD_FIND;
        else c.cmd = ct_pkg::CMD_READ;
      end
      PH_DRAIN: begin
        if (r < 70) c.cmd = ct_pkg::CMD_REMOVE;
        else if (r < 80) c.cmd = ct_pkg::CMD_ADD;
        else if (r < 90) c.cmd = ct_pkg::CMD_FIND;
        else c.cmd = ct_pkg::CMD_READ;
      end
      default: begin
        if (r < 35) c.cmd = ct_pkg::CMD_ADD;
        else if (r < 60) c.cmd = ct_pkg::CMD_REMOVE;
        else if (r < 80) c.cmd = ct_pkg::CMD_FIND;
        else c.cmd = ct_pkg::CMD_READ;
      end
    endcase
    if (c.cmd == ct_pkg::CMD_REMOVE || c.cmd == ct_pkg::CMD_FIND) begin
      // present ids mostly, near misses otherwise
      if ($urandom_range(0, 9) < 8) c.key_id = sb.any_present();
      else c.key_id = ID_W'($urandom_range(0, sb.used + 2));
    end
    if (c.cmd == ct_pkg::CMD_READ) begin
      if ($urandom_range(0, 9) < 8 && sb.used > 0)
        c.slot_index = IDX_W'($urandom_range(0, sb.used - 1));
      else if (sb.used < TBL_DEPTH)
        c.slot_index = IDX_W'($urandom_range(sb.used, TBL_DEPTH - 1));
    end
    return c;
  endfunction

  initial begin
    phase_t ph;
    int     sent;
    int     n;
    int     tail_n;
    int     phase_no;
    bit     over;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty table, first ids, gap reuse, edge keys and slots
    send_command(mk(ct_pkg::CMD_READ, 0, 0));           // read on empty table
    send_command(mk(ct_pkg::CMD_FIND, 0, 0));
    send_command(mk(ct_pkg::CMD_REMOVE, 16'hFFFF, 0));  // remove from empty table
    send_command(mk(ct_pkg::CMD_ADD, 0, 0));
    send_command(mk(ct_pkg::CMD_ADD, 0, 0));
    send_command(mk(ct_pkg::CMD_ADD, 0, 0));
    send_command(mk(ct_pkg::CMD_ADD, 0, 0));
    send_command(mk(ct_pkg::CMD_FIND, 1, 0));
    send_command(mk(ct_pkg::CMD_FIND, 4, 0));
    send_command(mk(ct_pkg::CMD_READ, 0, 0));
    send_command(mk(ct_pkg::CMD_READ, 0, 3));
    send_command(mk(ct_pkg::CMD_READ, 0, 4));           // just past the used count
    send_command(mk(ct_pkg::CMD_READ, 0, 7'h7F));
    send_command(mk(ct_pkg::CMD_REMOVE, 2, 0));         // middle entry, later ones shift down
    send_command(mk(ct_pkg::CMD_READ, 0, 1));
    send_command(mk(ct_pkg::CMD_ADD, 0, 0));            // freed id comes back at the end
    send_command(mk(ct_pkg::CMD_READ, 0, 3));
    send_command(mk(ct_pkg::CMD_REMOVE, 1, 0));         // first entry
    send_command(mk(ct_pkg::CMD_REMOVE, 2, 0));         // last entry
    send_command(mk(ct_pkg::CMD_FIND, 0, 0));           // id zero is never handed out
    send_command(mk(ct_pkg::CMD_FIND, 16'hFFFF, 0));
    send_command(mk(ct_pkg::CMD_REMOVE, 3, 0));
    send_command(mk(ct_pkg::CMD_REMOVE, 4, 0));
    send_command(mk(ct_pkg::CMD_REMOVE, 3, 0));         // already gone

    // random: fill to full, mix, drain to empty, mix, and around again
    sent = 0;
    phase_no = 0;
    while (sent < RAND_ITEMS) begin
      case (phase_no % 4)
        0: ph = PH_FILL;
        2: ph = PH_DRAIN;
        default: ph = PH_MIX;
      endcase
      n = 0;
      tail_n = 0;
      over = 1'b0;
      while (!over && sent < RAND_ITEMS) begin
        steady = (sent >= 120 && sent < 260);
        send_command(make_command(ph));
        sent++;
        n++;
        if (sb.used >= TBL_DEPTH) full_hits++;
        case (ph)
          PH_FILL: begin
            if (sb.used >= TBL_DEPTH) tail_n++;
            over = (tail_n > 6) || (n >= 260);
          end
          PH_DRAIN: begin
            if (sb.used == 0) tail_n++;
            over = (tail_n > 4) || (n >= 260);
          end
          default: over = (n >= 80);
        endcase
      end
      phase_no++;
    end
    steady = 1'b0;
    in_valid = 1'b0;

    // drain outstanding answers, then watch a little longer for strays
    while (sb.pending_answers.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending_answers.size() != 0)
      sb.report_mismatch($sformatf("%0d answers never arrived", sb.pending_answers.size()));

    $display("covered %0d commands: add %0d, remove %0d, find %0d, read %0d",
             sb.accepted, sb.cmd_seen[ct_pkg::CMD_ADD], sb.cmd_seen[ct_pkg::CMD_REMOVE],
             sb.cmd_seen[ct_pkg::CMD_FIND], sb.cmd_seen[ct_pkg::CMD_READ]);
    $display("%0d answers: ok %0d, full %0d, missing id %0d, bad slot %0d; peak %0d, full %0d",
             sb.answered, sb.status_seen[ct_pkg::ST_OK], sb.status_seen[ct_pkg::ST_FULL],
             sb.status_seen[ct_pkg::ST_NOT_FOUND], sb.status_seen[ct_pkg::ST_RANGE],
             sb.peak_used, full_hits);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
